### rtl/gcmp_pkg.sv
// ----------------------------------------------------------------------------
// gcmp_pkg
// Shared types, message codes and length table for the grid controller
// message parser.
// ----------------------------------------------------------------------------
package gcmp_pkg;

    localparam int DEF_MAX_COLUMNS  = 16;
    localparam int DEF_MAX_ROWS     = 16;
    localparam int DEF_MAX_ENCODERS = 4;

    localparam int IN_DATA_W  = 8;
    localparam int RESULT_W   = 42;
    localparam int OUT_DATA_W = 48;

    localparam logic [7:0] PAD_BYTE      = 8'hFF;
    localparam logic [7:0] ENC_SUBSYS_ID = 8'h05;

    localparam logic [3:0] SUB_SYSTEM = 4'h0;
    localparam logic [3:0] SUB_KEY    = 4'h2;
    localparam logic [3:0] SUB_ENC    = 4'h5;
    localparam logic [3:0] SUB_TILT   = 4'h8;

    localparam logic [3:0] CMD_SYS_QUERY = 4'h0;
    localparam logic [3:0] CMD_SYS_ID    = 4'h1;
    localparam logic [3:0] CMD_SYS_OFS   = 4'h2;
    localparam logic [3:0] CMD_SYS_SIZE  = 4'h3;
    localparam logic [3:0] CMD_SYS_ADDR  = 4'h4;
    localparam logic [3:0] CMD_SYS_VER   = 4'hF;

    localparam logic [3:0] CMD_KEY_UP   = 4'h0;
    localparam logic [3:0] CMD_KEY_DOWN = 4'h1;

    localparam logic [3:0] CMD_ENC_DELTA = 4'h0;
    localparam logic [3:0] CMD_ENC_UP    = 4'h1;
    localparam logic [3:0] CMD_ENC_DOWN  = 4'h2;

    localparam logic [3:0] CMD_TILT_ACT  = 4'h0;
    localparam logic [3:0] CMD_TILT_DATA = 4'h1;

    localparam logic [1:0] KIND_GRID_KEY  = 2'd0;
    localparam logic [1:0] KIND_ENC_DELTA = 2'd1;
    localparam logic [1:0] KIND_ENC_KEY   = 2'd2;

    typedef struct packed {
        logic [7:0] cur_header;
        logic [7:0] first_arg;
        logic [7:0] second_arg;
        logic [5:0] bytes_received;
        logic [5:0] bytes_expected;
        logic [4:0] cols_found;
        logic [4:0] rows_found;
        logic [2:0] encoders_found;
        logic       arc_found;
    } parse_state_t;

    // Declared from the highest bit down so that event_valid lands in bit 0.
    typedef struct packed {
        logic              arc_mode;
        logic [2:0]        encoder_count;
        logic [4:0]        grid_rows;
        logic [4:0]        grid_columns;
        logic signed [7:0] delta;
        logic              pressed;
        logic [7:0]        key_y;
        logic [7:0]        key_x_or_encoder;
        logic [1:0]        event_kind;
        logic              event_valid;
    } result_t;

    function automatic logic [5:0] msg_length(input logic [7:0] hdr);
        logic [3:0] sub;
        logic [3:0] cmd;
        logic [5:0] len;
        sub = hdr[7:4];
        cmd = hdr[3:0];
        len = 6'd1;
        case (sub)
            SUB_SYSTEM:
            begin
                case (cmd)
                    CMD_SYS_QUERY: len = 6'd3;
                    CMD_SYS_ID:    len = 6'd33;
                    CMD_SYS_OFS:   len = 6'd4;
                    CMD_SYS_SIZE:  len = 6'd3;
                    CMD_SYS_ADDR:  len = 6'd3;
                    CMD_SYS_VER:   len = 6'd9;
                    default:       len = 6'd1;
                endcase
            end
            SUB_KEY:
            begin
                len = (cmd <= CMD_KEY_DOWN) ? 6'd3 : 6'd1;
            end
            SUB_ENC:
            begin
                case (cmd)
                    CMD_ENC_DELTA: len = 6'd3;
                    CMD_ENC_UP:    len = 6'd2;
                    CMD_ENC_DOWN:  len = 6'd2;
                    default:       len = 6'd1;
                endcase
            end
            SUB_TILT:
            begin
                case (cmd)
                    CMD_TILT_ACT:  len = 6'd2;
                    CMD_TILT_DATA: len = 6'd8;
                    default:       len = 6'd1;
                endcase
            end
            default: len = 6'd1;
        endcase
        return len;
    endfunction

endpackage

### rtl/gcmp_decode.sv
// ----------------------------------------------------------------------------
// gcmp_decode
// Per-byte framing and dispatch logic: from the parser state and one byte it
// forms the next state and the result word.
// ----------------------------------------------------------------------------
module gcmp_decode #(
    parameter int MAX_COLUMNS  = gcmp_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS     = gcmp_pkg::DEF_MAX_ROWS,
    parameter int MAX_ENCODERS = gcmp_pkg::DEF_MAX_ENCODERS
) (
    input  gcmp_pkg::parse_state_t st,
    input  logic [7:0]             rx_byte,
    output gcmp_pkg::parse_state_t st_next,
    output gcmp_pkg::result_t      res
);
    import gcmp_pkg::*;

    localparam logic [7:0] COL_LIMIT = 8'(MAX_COLUMNS);
    localparam logic [7:0] ROW_LIMIT = 8'(MAX_ROWS);
    localparam logic [7:0] ENC_LIMIT = 8'(MAX_ENCODERS);
    localparam logic [5:0] RECV_MAX  = 6'd63;

    logic [5:0] msg_len;
    logic [5:0] recv_inc;
    logic [5:0] exp_len;
    logic       dispatch;
    logic [3:0] sub;
    logic [3:0] cmd;
    logic [7:0] enc_clamped;
    parse_state_t nxt;

    assign msg_len  = msg_length(rx_byte);
    assign recv_inc = (st.bytes_received < RECV_MAX) ? st.bytes_received + 6'd1
                                                     : st.bytes_received;

    always_comb
    begin
        nxt      = st;
        res      = '0;
        dispatch = 1'b0;
        exp_len  = st.bytes_expected;

        if (st.bytes_expected == 6'd0)
        begin
            if (rx_byte != PAD_BYTE)
            begin
                nxt.cur_header     = rx_byte;
                nxt.bytes_received = 6'd1;
                nxt.bytes_expected = msg_len;
                exp_len            = msg_len;
                dispatch           = (msg_len <= 6'd1);
            end
        end
        else
        begin
            if (st.bytes_received == 6'd1)
            begin
                nxt.first_arg = rx_byte;
            end
            else if (st.bytes_received == 6'd2)
            begin
                nxt.second_arg = rx_byte;
            end
            nxt.bytes_received = recv_inc;
            dispatch           = (recv_inc >= st.bytes_expected);
        end

        sub         = nxt.cur_header[7:4];
        cmd         = nxt.cur_header[3:0];
        enc_clamped = (nxt.second_arg > ENC_LIMIT) ? ENC_LIMIT : nxt.second_arg;

        if (dispatch)
        begin
            nxt.bytes_expected = 6'd0;
            nxt.bytes_received = 6'd0;
            case (sub)
                SUB_SYSTEM:
                begin
                    if (cmd == CMD_SYS_SIZE && exp_len == 6'd3)
                    begin
                        if (nxt.first_arg != 8'd0 && nxt.first_arg <= COL_LIMIT)
                        begin
                            nxt.cols_found = nxt.first_arg[4:0];
                        end
                        if (nxt.second_arg != 8'd0 && nxt.second_arg <= ROW_LIMIT)
                        begin
                            nxt.rows_found = nxt.second_arg[4:0];
                        end
                    end
                    else if (cmd == CMD_SYS_QUERY && exp_len == 6'd3)
                    begin
                        if (nxt.first_arg == ENC_SUBSYS_ID)
                        begin
                            nxt.encoders_found = enc_clamped[2:0];
                            if (enc_clamped != 8'd0)
                            begin
                                nxt.arc_found = 1'b1;
                            end
                        end
                    end
                end
                SUB_KEY:
                begin
                    if (cmd <= CMD_KEY_DOWN)
                    begin
                        res.event_valid      = 1'b1;
                        res.key_x_or_encoder = nxt.first_arg;
                        res.pressed          = cmd[0];
                        if (st.arc_found)
                        begin
                            res.event_kind = KIND_ENC_KEY;
                        end
                        else
                        begin
                            res.event_kind = KIND_GRID_KEY;
                            res.key_y      = nxt.second_arg;
                        end
                    end
                end
                SUB_ENC:
                begin
                    if (cmd == CMD_ENC_DELTA)
                    begin
                        res.event_valid      = 1'b1;
                        res.event_kind       = KIND_ENC_DELTA;
                        res.key_x_or_encoder = nxt.first_arg;
                        res.delta            = nxt.second_arg;
                    end
                    else if (cmd == CMD_ENC_UP || cmd == CMD_ENC_DOWN)
                    begin
                        res.event_valid      = 1'b1;
                        res.event_kind       = KIND_ENC_KEY;
                        res.key_x_or_encoder = nxt.first_arg;
                        res.pressed          = (cmd == CMD_ENC_DOWN);
                    end
                end
                default:
                begin
                    res.event_valid = 1'b0;
                end
            endcase
        end

        res.grid_columns  = nxt.cols_found;
        res.grid_rows     = nxt.rows_found;
        res.encoder_count = nxt.encoders_found;
        res.arc_mode      = nxt.arc_found;
        st_next           = nxt;
    end

endmodule

### rtl/grid_controller_message_parser.sv
// ----------------------------------------------------------------------------
// grid_controller_message_parser
// Parses a stream of received serial bytes into grid and encoder events and
// tracks the discovered grid size and encoder count.
// ----------------------------------------------------------------------------
// A result word appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output is not stalled; the
// decode runs in a single pass between the parser state register and the
// output register. Reset clears the parser state and the discovered sizes
// and empties the output register.
module grid_controller_message_parser #(
    parameter int MAX_COLUMNS  = gcmp_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS     = gcmp_pkg::DEF_MAX_ROWS,
    parameter int MAX_ENCODERS = gcmp_pkg::DEF_MAX_ENCODERS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: rx_byte[7:0].
    input  logic [gcmp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: event_valid[0], event_kind[2:1], key_x_or_encoder[10:3],
    // key_y[18:11], pressed[19], delta[27:20], grid_columns[32:28],
    // grid_rows[37:33], encoder_count[40:38], arc_mode[41], zero fill[47:42].
    output logic [gcmp_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import gcmp_pkg::*;

    parse_state_t st_reg;
    parse_state_t st_next;
    result_t      res_reg;
    result_t      res_next;
    logic         out_valid_reg;
    logic         accept;

    gcmp_decode #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .MAX_ROWS     (MAX_ROWS),
        .MAX_ENCODERS (MAX_ENCODERS)
    ) u_decode (
        .st      (st_reg),
        .rx_byte (s_axis_tdata),
        .st_next (st_next),
        .res     (res_next)
    );

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                st_reg <= st_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, res_reg};

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the grid controller message parser. Bytes are
// sent over the input stream with random gaps. Every accepted byte is run
// through a behavioral parser that produces the expected result word. The
// result words are compared field by field as they leave the output stream,
// and the output side stalls at random. Grid-mode traffic runs first, then
// an encoder device is discovered and arc-mode traffic follows.
// ----------------------------------------------------------------------------
module tb_top;
    import gcmp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 900;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Behavioral parser state.
    logic [7:0] p_header = '0;
    logic [7:0] p_arg1 = '0;
    logic [7:0] p_arg2 = '0;
    logic [5:0] p_received = '0;
    logic [5:0] p_expected = '0;
    logic [4:0] p_cols = '0;
    logic [4:0] p_rows = '0;
    logic [2:0] p_encoders = '0;
    logic       p_arc = 1'b0;

    result_t pending_results[$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      results_seen = 0;
    bit      tx_idle = 1'b1;
    bit      rx_idle = 1'b1;
    int      rx_hold_len = 0;

    grid_controller_message_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [5:0] frame_length(input logic [7:0] hdr);
        logic [5:0] n;
        n = 6'd1;
        case (hdr[7:4])
            SUB_SYSTEM:
            begin
                case (hdr[3:0])
                    CMD_SYS_QUERY, CMD_SYS_SIZE, CMD_SYS_ADDR: n = 6'd3;
                    CMD_SYS_ID:  n = 6'd33;
                    CMD_SYS_OFS: n = 6'd4;
                    CMD_SYS_VER: n = 6'd9;
                    default:     n = 6'd1;
                endcase
            end
            SUB_KEY:
            begin
                if (hdr[3:0] <= CMD_KEY_DOWN)
                    n = 6'd3;
            end
            SUB_ENC:
            begin
                if (hdr[3:0] == CMD_ENC_DELTA)
                    n = 6'd3;
                else if (hdr[3:0] == CMD_ENC_UP || hdr[3:0] == CMD_ENC_DOWN)
                    n = 6'd2;
            end
            SUB_TILT:
            begin
                if (hdr[3:0] == CMD_TILT_ACT)
                    n = 6'd2;
                else if (hdr[3:0] == CMD_TILT_DATA)
                    n = 6'd8;
            end
            default: n = 6'd1;
        endcase
        return n;
    endfunction

    // Advances the parser state by one byte and returns the result word it yields.
    function automatic result_t parse_byte(input logic [7:0] b);
        result_t    r;
        logic       done;
        logic [3:0] sub;
        logic [3:0] cmd;
        r = '0;
        done = 1'b0;
        if (p_expected == 6'd0)
        begin
            if (b != PAD_BYTE)
            begin
                p_header = b;
                p_received = 6'd1;
                p_expected = frame_length(b);
                done = (p_expected <= 6'd1);
            end
        end
        else
        begin
            if (p_received == 6'd1)
                p_arg1 = b;
            else if (p_received == 6'd2)
                p_arg2 = b;
            if (p_received < 6'd63)
                p_received = p_received + 6'd1;
            done = (p_received >= p_expected);
        end
        if (done)
        begin
            sub = p_header[7:4];
            cmd = p_header[3:0];
            if (sub == SUB_SYSTEM && p_expected == 6'd3)
            begin
                if (cmd == CMD_SYS_SIZE)
                begin
                    if (p_arg1 > 0 && p_arg1 <= DEF_MAX_COLUMNS)
                        p_cols = p_arg1[4:0];
                    if (p_arg2 > 0 && p_arg2 <= DEF_MAX_ROWS)
                        p_rows = p_arg2[4:0];
                end
                else if (cmd == CMD_SYS_QUERY && p_arg1 == ENC_SUBSYS_ID)
                begin
                    p_encoders = (p_arg2 > DEF_MAX_ENCODERS) ? 3'(DEF_MAX_ENCODERS) : p_arg2[2:0];
                    if (p_encoders != 3'd0)
                        p_arc = 1'b1;
                end
            end
            else if (sub == SUB_KEY && cmd <= CMD_KEY_DOWN)
            begin
                r.event_valid = 1'b1;
                r.key_x_or_encoder = p_arg1;
                r.pressed = cmd[0];
                if (p_arc)
                    r.event_kind = KIND_ENC_KEY;
                else
                begin
                    r.event_kind = KIND_GRID_KEY;
                    r.key_y = p_arg2;
                end
            end
            else if (sub == SUB_ENC && cmd == CMD_ENC_DELTA)
            begin
                r.event_valid = 1'b1;
                r.event_kind = KIND_ENC_DELTA;
                r.key_x_or_encoder = p_arg1;
                r.delta = p_arg2;
            end
            else if (sub == SUB_ENC && (cmd == CMD_ENC_UP || cmd == CMD_ENC_DOWN))
            begin
                r.event_valid = 1'b1;
                r.event_kind = KIND_ENC_KEY;
                r.key_x_or_encoder = p_arg1;
                r.pressed = (cmd == CMD_ENC_DOWN);
            end
            p_expected = 6'd0;
            p_received = 6'd0;
        end
        r.grid_columns = p_cols;
        r.grid_rows = p_rows;
        r.encoder_count = p_encoders;
        r.arc_mode = p_arc;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s: got %0h expected %0h",
                                      results_seen, name, got, want));
    endtask

    // Called at a falling edge; returns at the falling edge after the byte is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        repeat (gap)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = b;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        pending_results.push_back(parse_byte(b));
        @(negedge clk);
    endtask

    task automatic wait_all_results;
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic send_random_message(input bit arc_allowed, inout int sent);
        int         pick;
        int         i;
        logic [3:0] sub;
        logic [3:0] cmd;
        logic [7:0] hdr;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [5:0] len;
        pick = $urandom_range(0, 99);
        a1 = 8'($urandom);
        a2 = 8'($urandom);
        hdr = '0;
        if (pick < 22)
        begin
            cmd = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(2, 15))
                                              : 4'($urandom_range(0, 1));
            hdr = {SUB_KEY, cmd};
        end
        else if (pick < 44)
        begin
            cmd = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(3, 15))
                                              : 4'($urandom_range(0, 2));
            if ($urandom_range(0, 1) == 1)
                a1 = 8'($urandom_range(0, 7));
            hdr = {SUB_ENC, cmd};
        end
        else if (pick < 54)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                a1 = 8'($urandom_range(0, 20));
                a2 = 8'($urandom_range(0, 20));
            end
            hdr = {SUB_SYSTEM, CMD_SYS_SIZE};
        end
        else if (pick < 62)
        begin
            if ($urandom_range(0, 2) != 0)
                a1 = ENC_SUBSYS_ID;
            if ($urandom_range(0, 1) == 1)
                a2 = 8'($urandom_range(0, 8));
            if (!arc_allowed && a1 == ENC_SUBSYS_ID)
                a2 = 8'd0;
            hdr = {SUB_SYSTEM, CMD_SYS_QUERY};
        end
        else if (pick < 70)
        begin
            case ($urandom_range(0, 4))
                0: cmd = CMD_SYS_ID;
                1: cmd = CMD_SYS_OFS;
                2: cmd = CMD_SYS_ADDR;
                3: cmd = CMD_SYS_VER;
                default: cmd = 4'($urandom);
            endcase
            hdr = {SUB_SYSTEM, cmd};
        end
        else if (pick < 78)
        begin
            cmd = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(2, 15))
                                              : 4'($urandom_range(0, 1));
            hdr = {SUB_TILT, cmd};
        end
        else if (pick < 94)
        begin
            sub = 4'($urandom);
            while (sub == SUB_SYSTEM || sub == SUB_KEY || sub == SUB_ENC || sub == SUB_TILT)
                sub = 4'($urandom);
            hdr = {sub, 4'($urandom)};
        end
        if (pick >= 94)
        begin
            // Padding between messages, or a stray byte that breaks the framing.
            if (pick < 97)
                repeat ($urandom_range(1, 4)) send_byte(PAD_BYTE);
            else
            begin
                send_byte(8'($urandom));
                sent++;
            end
        end
        else
        begin
            len = frame_length(hdr);
            send_byte(hdr);
            sent++;
            for (i = 1; i < len; i++)
            begin
                send_byte((i == 1) ? a1 : (i == 2) ? a2 : 8'($urandom));
                sent++;
            end
        end
    endtask

    task automatic run_random_traffic(input bit arc_allowed);
        int sent;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                tx_idle = ($urandom_range(0, 2) != 0);
                rx_idle = ($urandom_range(0, 2) != 0);
            end
            send_random_message(arc_allowed, sent);
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        wait_all_results();
    endtask

    task automatic test_grid_directed;
        send_byte(PAD_BYTE);
        send_byte({SUB_KEY, CMD_KEY_UP});
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte({SUB_KEY, CMD_KEY_DOWN});
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte({SUB_SYSTEM, CMD_SYS_SIZE});
        send_byte(8'd16);
        send_byte(8'd16);
        send_byte({SUB_SYSTEM, CMD_SYS_SIZE});
        send_byte(8'd0);
        send_byte(8'd17);
        send_byte({SUB_KEY, CMD_KEY_DOWN + 4'd1});
        send_byte({SUB_ENC, CMD_ENC_DELTA});
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte({SUB_ENC, CMD_ENC_DELTA});
        send_byte(8'h00);
        send_byte(8'h7F);
        wait_all_results();
    endtask

    task automatic test_grid_random;
        run_random_traffic(1'b0);
    endtask

    task automatic test_backpressure;
        int sent;
        sent = 0;
        tx_idle = 1'b0;
        rx_hold_len = 60;
        while (sent < 30)
            send_random_message(1'b0, sent);
        tx_idle = 1'b1;
        wait_all_results();
    endtask

    task automatic test_arc_directed;
        send_byte({SUB_SYSTEM, CMD_SYS_QUERY});
        send_byte(ENC_SUBSYS_ID);
        send_byte(8'd200);
        send_byte({SUB_KEY, CMD_KEY_DOWN});
        send_byte(8'd3);
        send_byte(8'd9);
        send_byte({SUB_ENC, CMD_ENC_UP});
        send_byte(8'd2);
        send_byte({SUB_ENC, CMD_ENC_DOWN});
        send_byte(8'd3);
        send_byte({SUB_ENC, CMD_ENC_DOWN + 4'd1});
        wait_all_results();
    endtask

    task automatic test_arc_random;
        run_random_traffic(1'b1);
    endtask

    // Output side: a random wait before each word, or one long hold on request.
    initial
    begin : result_drain
        int n;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (rx_hold_len != 0)
            begin
                n = rx_hold_len;
                rx_hold_len = 0;
            end
            else
                n = rx_idle ? $urandom_range(0, 12) : 0;
            repeat (n)
            begin
                m_axis_tready = 1'b0;
                @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            results_seen++;
            got = result_t'(m_axis_tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0)
                report_mismatch($sformatf("word %0d arrived with none expected", results_seen));
            else
            begin
                want = pending_results.pop_front();
                compare_field("event_valid", 8'(got.event_valid), 8'(want.event_valid));
                compare_field("event_kind", 8'(got.event_kind), 8'(want.event_kind));
                compare_field("key_x_or_encoder", got.key_x_or_encoder, want.key_x_or_encoder);
                compare_field("key_y", got.key_y, want.key_y);
                compare_field("pressed", 8'(got.pressed), 8'(want.pressed));
                compare_field("delta", got.delta, want.delta);
                compare_field("grid_columns", 8'(got.grid_columns), 8'(want.grid_columns));
                compare_field("grid_rows", 8'(got.grid_rows), 8'(want.grid_rows));
                compare_field("encoder_count", 8'(got.encoder_count), 8'(want.encoder_count));
                compare_field("arc_mode", 8'(got.arc_mode), 8'(want.arc_mode));
                compare_field("zero fill", 8'(m_axis_tdata[OUT_DATA_W-1:RESULT_W]), 8'd0);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_grid_directed();
        test_grid_random();
        test_backpressure();
        test_arc_directed();
        test_arc_random();
        wait_all_results();
        repeat (4) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", pending_results.size()));
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/gcmp_pkg.sv
rtl/gcmp_decode.sv
rtl/grid_controller_message_parser.sv
tb/sv/tb_top.sv
